>>> hw/rtl/pee_pkg.sv
// Shared constants, codes and types for the postfix expression evaluator.
package pee_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int STEP_W      = $clog2(DATA_W);
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 40;

  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_REM  = 8'h25;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_REM = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              div0;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

>>> hw/rtl/pee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pee_alu.sv
// Iterative shift-add multiplier and signed restoring divider sharing one datapath.
module pee_alu (
  input  logic                     clk,
  input  logic                     rst,
  input  pee_pkg::alu_req_t        req,
  input  logic [pee_pkg::DATA_W-1:0] a,
  input  logic [pee_pkg::DATA_W-1:0] b,
  output pee_pkg::alu_rsp_t        rsp
);
  import pee_pkg::*;

  logic              busy;
  logic              fin;
  logic [STEP_W-1:0] step;
  op_t               op_q;
  logic              neg_q;
  logic              neg_r;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] quo;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  // One restoring division step: shift in the next dividend bit, try to subtract.
  assign rem_sh = {acc, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
      rsp.div0 <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        op_q     <= req.op;
        rsp.div0 <= 1'b0;
        acc      <= '0;
        if (req.op != OP_MUL && b == '0) begin
          rsp.done   <= 1'b1;
          rsp.div0   <= 1'b1;
          rsp.result <= '0;
        end else begin
          busy <= 1'b1;
          step <= STEP_W'(DATA_W - 1);
          if (req.op == OP_MUL) begin
            dvs <= a;
            quo <= b;
          end else begin
            dvs   <= b[DATA_W-1] ? -b : b;
            quo   <= a[DATA_W-1] ? -a : a;
            neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
            neg_r <= a[DATA_W-1];
          end
        end
      end else if (busy) begin
        if (op_q == OP_MUL) begin
          if (quo[0]) begin
            acc <= acc + dvs;
          end
          dvs <= {dvs[DATA_W-2:0], 1'b0};
          quo <= {1'b0, quo[DATA_W-1:1]};
        end else begin
          if (!diff[DATA_W]) begin
            acc <= diff[DATA_W-1:0];
          end else begin
            acc <= rem_sh[DATA_W-1:0];
          end
          quo <= {quo[DATA_W-2:0], ~diff[DATA_W]};
        end
        if (step == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          step <= step - STEP_W'(1);
        end
      end else if (fin) begin
        fin      <= 1'b0;
        rsp.done <= 1'b1;
        rsp.div0 <= 1'b0;
        case (op_q)
          OP_MUL:  rsp.result <= acc;
          OP_DIV:  rsp.result <= neg_q ? -quo : quo;
          OP_REM:  rsp.result <= neg_r ? -acc : acc;
          default: rsp.result <= '0;
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/postfix_expression_evaluator_core.sv
// Postfix expression evaluator: character decoder, operand stack and sequencer.
// Characters are taken one at a time, a new one only in the idle state. '*', '/'
// and '%' wait on the 32-step shift unit that serves all three, which skips its
// steps when the divisor is zero. The final character also flushes any pending
// number and reads the top of the stack before the result transfer is offered.
// Reset is synchronous and active high; it clears the sequencer, the stack
// count, the number accumulator and the status, but not the stack RAM.
module postfix_expression_evaluator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pee_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] char_code
  input  logic                          s_tlast,  // end_of_expr
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pee_pkg::M_TDATA_W-1:0] m_tdata   // [31:0] value, [33:32] status, zero fill
);
  import pee_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DECODE = 12'b000000000010,
    S_RD_B   = 12'b000000000100,
    S_RD_A   = 12'b000000001000,
    S_LD_A   = 12'b000000010000,
    S_EXEC   = 12'b000000100000,
    S_ALU    = 12'b000001000000,
    S_NOT_WB = 12'b000010000000,
    S_FLUSH  = 12'b000100000000,
    S_FIN_RD = 12'b001000000000,
    S_FIN_LD = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t            state;
  logic [7:0]        ch;
  logic              last;
  logic [DATA_W-1:0] acc;
  logic              in_num;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        err;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] res_val;

  logic              is_digit;
  logic              is_binop;
  logic              is_addsub;
  logic              has_room;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [DATA_W-1:0] acc_x10;
  logic [DATA_W-1:0] digit;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  state_t            done_state;

  assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
  assign is_addsub = (ch == CH_ADD) || (ch == CH_SUB);
  assign is_binop  = is_addsub || (ch == CH_MUL) || (ch == CH_DIV) || (ch == CH_REM);
  assign has_room  = cnt < CNT_W'(STACK_DEPTH);
  assign cnt_m1    = cnt - CNT_W'(1);
  assign cnt_m2    = cnt - CNT_W'(2);

  // Times ten as two shifted copies added together, then the new digit.
  assign acc_x10 = {acc[DATA_W-4:0], 3'b000} + {acc[DATA_W-2:0], 1'b0};
  assign digit   = DATA_W'(ch - CH_0);

  // After a character is dealt with, the last one of an expression goes on to
  // flush any pending number and read the top of the stack.
  assign done_state = last ? S_FLUSH : S_IDLE;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    alu_req.start = (state == S_EXEC) && !is_addsub;
    case (ch)
      CH_DIV:  alu_req.op = OP_DIV;
      CH_REM:  alu_req.op = OP_REM;
      default: alu_req.op = OP_MUL;
    endcase
  end

  // Stack RAM ports. A push always writes at the current count; '!' rewrites the top.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[ADDR_W-1:0];
    ram_wdata = acc;
    ram_raddr = (state == S_RD_A) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
    case (state)
      S_DECODE: ram_we = !is_digit && in_num && has_room;
      S_FLUSH:  ram_we = in_num && has_room;
      S_NOT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_m1[ADDR_W-1:0];
        ram_wdata = (ram_rdata == '0) ? DATA_W'(1) : '0;
      end
      S_EXEC: begin
        ram_we    = is_addsub;
        ram_wdata = (ch == CH_ADD) ? opa + opb : opa - opb;
      end
      S_ALU: begin
        ram_we    = alu_rsp.done;
        ram_wdata = alu_rsp.result;
      end
      default: ram_we = 1'b0;
    endcase
  end

  pee_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pee_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (opa),
    .b   (opb),
    .rsp (alu_rsp)
  );

  // Keeps the first error only.
  function automatic logic [1:0] flag(input logic [1:0] cur, input logic [1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      acc      <= '0;
      in_num   <= 1'b0;
      cnt      <= '0;
      err      <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      // A taken result is dropped here unless a new one is loaded below.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ch    <= s_tdata;
            last  <= s_tlast;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (is_digit) begin
            acc    <= acc_x10 + digit;
            in_num <= 1'b1;
            state  <= done_state;
          end else if (in_num) begin
            // The character that ends a number is only its separator.
            if (has_room) begin
              cnt <= cnt + CNT_W'(1);
            end else begin
              err <= flag(err, ST_OVER);
            end
            acc    <= '0;
            in_num <= 1'b0;
            state  <= done_state;
          end else if (ch == CH_BANG) begin
            if (cnt != '0) begin
              state <= S_RD_B;
            end else begin
              err   <= flag(err, ST_UNDER);
              state <= done_state;
            end
          end else if (is_binop) begin
            if (cnt >= CNT_W'(2)) begin
              state <= S_RD_B;
            end else begin
              err   <= flag(err, ST_UNDER);
              state <= done_state;
            end
          end else begin
            state <= done_state;
          end
        end
        S_RD_B: begin
          state <= (ch == CH_BANG) ? S_NOT_WB : S_RD_A;
        end
        S_RD_A: begin
          opb   <= ram_rdata;
          state <= S_LD_A;
        end
        S_LD_A: begin
          opa   <= ram_rdata;
          cnt   <= cnt_m2;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (is_addsub) begin
            cnt   <= cnt + CNT_W'(1);
            state <= done_state;
          end else begin
            state <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_rsp.done) begin
            cnt <= cnt + CNT_W'(1);
            if (alu_rsp.div0) begin
              err <= flag(err, ST_DIV0);
            end
            state <= done_state;
          end
        end
        S_NOT_WB: begin
          state <= done_state;
        end
        S_FLUSH: begin
          if (in_num) begin
            if (has_room) begin
              cnt <= cnt + CNT_W'(1);
            end else begin
              err <= flag(err, ST_OVER);
            end
          end
          acc    <= '0;
          in_num <= 1'b0;
          state  <= S_FIN_RD;
        end
        S_FIN_RD: begin
          if (cnt == '0) begin
            res_val <= '0;
            state   <= S_OUT;
          end else begin
            state <= S_FIN_LD;
          end
        end
        S_FIN_LD: begin
          res_val <= ram_rdata;
          state   <= S_OUT;
        end
        S_OUT: begin
          // Waits here only while an earlier result transfer is still pending.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(M_TDATA_W - DATA_W - 2)'(0), err, res_val};
            cnt      <= '0;
            err      <= ST_OK;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The stack count never passes the depth of the stack.
  assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // A push never writes into a full stack.
  assert property (@(posedge clk) disable iff (rst)
    ram_we && (state == S_DECODE || state == S_FLUSH || state == S_EXEC || state == S_ALU)
    |-> has_room)
    else $error("push into full stack");

  // A recorded error stays until the result is sent.
  assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK) && (state != S_OUT) |=> $stable(err))
    else $error("sticky status changed");

  // The shared unit only reports back while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) alu_rsp.done |-> state == S_ALU)
    else $error("unexpected arithmetic unit completion");

endmodule
